@@ hdl/dlp_pkg.sv @@
// directory listing parser: shared types, character codes and decode helpers
// no dependencies; imported by dlp_core and directory_listing_parser
`default_nettype none

package dlp_pkg;

  // parser phase register encoding
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ENTRY  = 4'd1,
    PH_NAME   = 4'd2,
    PH_LT     = 4'd3,
    PH_DIGITS = 4'd4,
    PH_TYPE   = 4'd5,
    PH_GT     = 4'd6,
    PH_AFTER  = 4'd7
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_NAME  = 3'd1,
    EV_ENTRY = 3'd2,
    EV_DIR   = 3'd3,
    EV_ERR   = 3'd4
  } event_t;

  // entry type codes
  localparam logic [2:0] TY_F = 3'd0;
  localparam logic [2:0] TY_M = 3'd1;
  localparam logic [2:0] TY_D = 3'd2;
  localparam logic [2:0] TY_U = 3'd3;
  localparam logic [2:0] TY_S = 3'd4;
  localparam logic [2:0] TY_B = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_B      = 8'h42;

  // largest resource number
  localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // fixed-width part of one result
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  name_byte;
    logic [30:0] entry_number;
    logic [2:0]  entry_type;
    logic [15:0] entry_count;
  } result_t;

  // type letter decode: {hit, code}
  function automatic logic [3:0] type_code(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      CH_F:    r = {1'b1, TY_F};
      CH_M:    r = {1'b1, TY_M};
      CH_D:    r = {1'b1, TY_D};
      CH_U:    r = {1'b1, TY_U};
      CH_S:    r = {1'b1, TY_S};
      CH_B:    r = {1'b1, TY_B};
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

  // bytes that may never appear in a name
  function automatic logic name_forbidden(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_SLASH);
  endfunction

endpackage

`default_nettype wire

@@ hdl/dlp_core.sv @@
// directory listing parser core: parse state registers and per-byte decode
// depends on dlp_pkg
`default_nettype none

module dlp_core #(
  parameter int NAME_MAX = 64,
  localparam int NW = $clog2(NAME_MAX + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      char_in,
  output dlp_pkg::result_t     res,
  output logic [NW-1:0]        name_length
);
  import dlp_pkg::*;

  localparam logic [NW-1:0] NAME_LIMIT = NW'(NAME_MAX);

  phase_t        phase, phase_next;
  logic [30:0]   acc, acc_next;
  logic [2:0]    type_held, type_next;
  logic [NW-1:0] name_count, name_count_next;
  logic [15:0]   seen, seen_next;

  logic [NW-1:0] count_base;
  logic [34:0]   acc_times_ten;
  logic [3:0]    digit;
  logic [3:0]    tcode;
  event_t        ev;

  // number accumulate: acc * 10 + digit
  assign digit         = 4'(char_in - CH_ZERO);
  assign acc_times_ten = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, digit};
  assign tcode         = type_code(char_in);
  // the name count restarts at the start of each entry
  assign count_base    = (phase == PH_ENTRY) ? '0 : name_count;

  // next state and result for the current byte
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    type_next       = type_held;
    name_count_next = name_count;
    seen_next       = seen;
    ev              = EV_NONE;
    res             = '0;
    name_length     = '0;

    unique case (phase)
      PH_IDLE: begin
        if (char_in == CH_SPACE) begin
          ev = EV_NONE;
        end else if (char_in == CH_LBRACE) begin
          acc_next        = '0;
          type_next       = '0;
          name_count_next = '0;
          seen_next       = '0;
          phase_next      = PH_ENTRY;
        end else begin
          ev = EV_ERR;
        end
      end
      PH_ENTRY, PH_NAME: begin
        name_count_next = count_base;
        if ((phase == PH_ENTRY) && (char_in == CH_RBRACE)) begin
          ev                = EV_DIR;
          res.entry_count   = seen;
          phase_next        = PH_IDLE;
          acc_next          = '0;
          type_next         = '0;
          name_count_next   = '0;
          seen_next         = '0;
        end else if (name_forbidden(char_in)) begin
          ev = EV_ERR;
        end else if (char_in == CH_COLON) begin
          acc_next   = '0;
          phase_next = PH_LT;
        end else if (count_base >= NAME_LIMIT) begin
          ev = EV_ERR;
        end else begin
          name_count_next = count_base + 1'b1;
          phase_next      = PH_NAME;
          res.name_byte   = char_in;
          ev              = EV_NAME;
        end
      end
      PH_LT: begin
        if (char_in == CH_LT) phase_next = PH_DIGITS;
        else ev = EV_ERR;
      end
      PH_DIGITS: begin
        if ((char_in >= CH_ZERO) && (char_in <= CH_NINE)) begin
          if (acc_times_ten > {4'b0, NUM_LIMIT}) ev = EV_ERR;
          else acc_next = acc_times_ten[30:0];
        end else if (char_in == CH_COMMA) begin
          phase_next = PH_TYPE;
        end else begin
          ev = EV_ERR;
        end
      end
      PH_TYPE: begin
        if (tcode[3]) begin
          type_next  = tcode[2:0];
          phase_next = PH_GT;
        end else begin
          ev = EV_ERR;
        end
      end
      PH_GT: begin
        if (char_in == CH_GT) begin
          res.entry_number = acc;
          res.entry_type   = type_held;
          name_length      = name_count;
          if (seen != COUNT_MAX) seen_next = seen + 1'b1;
          phase_next = PH_AFTER;
          ev         = EV_ENTRY;
        end else begin
          ev = EV_ERR;
        end
      end
      PH_AFTER: begin
        if (char_in == CH_RBRACE) begin
          ev                = EV_DIR;
          res.entry_count   = seen;
          phase_next        = PH_IDLE;
          acc_next          = '0;
          type_next         = '0;
          name_count_next   = '0;
          seen_next         = '0;
        end else if (char_in == CH_COMMA) begin
          phase_next = PH_ENTRY;
        end else begin
          ev = EV_ERR;
        end
      end
      default: ev = EV_ERR;
    endcase

    // any mismatch drops everything back to idle
    if (ev == EV_ERR) begin
      phase_next      = PH_IDLE;
      acc_next        = '0;
      type_next       = '0;
      name_count_next = '0;
      seen_next       = '0;
      res             = '0;
      name_length     = '0;
    end
    res.event_res = ev;
  end

  // parse state, updated once per transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      acc        <= '0;
      type_held  <= '0;
      name_count <= '0;
      seen       <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      acc        <= acc_next;
      type_held  <= type_next;
      name_count <= name_count_next;
      seen       <= seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  // an error always leaves the parser idle
  a_err_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && (res.event_res == EV_ERR) |=> phase == PH_IDLE)
    else $error("parser not idle after error");

  // the held name never exceeds its limit
  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_LIMIT)
    else $error("name count beyond limit");

  // an entry is only reported from the closing-angle phase
  a_entry_phase: assert property (@(posedge clk) disable iff (rst)
    advance && (res.event_res == EV_ENTRY) |-> phase == PH_GT)
    else $error("entry reported outside closing phase");

  // state holds while no byte moves on
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(acc) && $stable(seen))
    else $error("parse state changed without a transfer");
`endif

endmodule

`default_nettype wire

@@ hdl/directory_listing_parser.sv @@
// directory listing parser, one byte per transfer, one result per byte
// a byte passes through the input register, then the result register, to its result
// throughput: one byte per cycle unless a result stalls; combinational decode in dlp_core
// a result held by out_stall blocks a new byte only when the input register is full
// reset (rst, synchronous): clears both valids and returns the parser to idle, all counts zero
// depends on dlp_pkg and dlp_core
`default_nettype none

module directory_listing_parser #(
  parameter int NAME_MAX = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       char_in,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [2:0]                            event_res,
  output logic [7:0]                            name_byte,
  output logic [30:0]                           entry_number,
  output logic [2:0]                            entry_type,
  output logic [$clog2(NAME_MAX + 1)-1:0]       name_length,
  output logic [15:0]                           entry_count
);
  import dlp_pkg::*;

  localparam int NW = $clog2(NAME_MAX + 1);

  logic          held_valid;
  logic [7:0]    char_held;
  logic          out_free;
  logic          advance;
  result_t       res;
  logic [NW-1:0] len;

  // handshake: byte moves on when the result register is empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign advance  = held_valid && out_free;
  assign in_stall = held_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_held <= char_in;
    end
  end

  // decode and parse state
  dlp_core #(
    .NAME_MAX (NAME_MAX)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .char_in     (char_held),
    .res         (res),
    .name_length (len)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res    <= res.event_res;
      name_byte    <= res.name_byte;
      entry_number <= res.entry_number;
      entry_type   <= res.entry_type;
      name_length  <= len;
      entry_count  <= res.entry_count;
    end
  end

endmodule

`default_nettype wire
